[rtl/bbc_pkg.sv]
// Shared types, constants and helpers for the bracket balance checker.
// Used by every module in rtl/ except bbc_ram; depends on nothing.
package bbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int MAX_PAIRS   = 4;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PADDR_W     = 4;

  localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  // register indexes on the config port (word address)
  localparam logic [1:0] REG_PAIR_COUNT  = 2'd0;
  localparam logic [1:0] REG_OPEN_BYTES  = 2'd1;
  localparam logic [1:0] REG_CLOSE_BYTES = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BALANCED   = 3'd1,
    ST_UNEXPECTED = 3'd2,
    ST_UNCLOSED   = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_SKIPPED    = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  pair_count;
    logic [31:0] open_bytes;
    logic [31:0] close_bytes;
  } cfg_t;

  typedef struct packed {
    logic       is_open;
    logic       is_close;
    logic [7:0] want;      // opener that the matched closer pairs with
  } match_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [7:0]         top;
    logic [7:0]         below;
  } stack_view_t;

  // byte of pair i; pairs beyond the register width read as zero
  function automatic logic [7:0] pair_byte(input logic [31:0] regv, input int i);
    logic [63:0] wide;
    wide = {32'd0, regv} >> (8 * i);
    return wide[7:0];
  endfunction

endpackage

[rtl/bracket_balance_checker.sv]
// Bracket balance checker top level. The result of a request is registered in the
// output register as the request is accepted. Throughput: one request per cycle
// while the output is not stalled, limited by the single stack push or pop per byte.
// Reset (synchronous, rst_n low) clears config, stack depth, line to 1, column
// to 0 and the error latch; the stack RAM needs no clearing pass.
// Depends on bbc_pkg, bbc_cfg, bbc_match, bbc_stack, bbc_ram.
module bracket_balance_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_source_byte,
  input  logic                        in_final_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [15:0]                 out_line_number,
  output logic [15:0]                 out_column_number,
  output logic [7:0]                  out_open_byte_left,
  output logic                        out_program_done,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int DW = bbc_pkg::DEPTH_W;

  bbc_pkg::cfg_t        cfg;
  bbc_pkg::match_t      match;
  bbc_pkg::stack_view_t stk;

  logic             accept;
  logic             work;
  logic             push;
  logic             pop;
  logic             clear;
  logic             err_new;
  logic             depth_after_nz;
  logic [7:0]       top_after;
  bbc_pkg::status_t status;
  logic [7:0]       left;

  logic [15:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic        err_r, err_nxt;

  logic             out_valid_r;
  bbc_pkg::status_t status_r;
  logic [15:0]      line_out_r;
  logic [15:0]      col_out_r;
  logic [7:0]       left_r;
  logic             done_r;

  bbc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  bbc_match u_match (
    .cfg    (cfg),
    .byte_in(in_source_byte),
    .match  (match)
  );

  bbc_stack u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .clear    (clear),
    .push_byte(in_source_byte),
    .view     (stk)
  );

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign work     = accept & ~err_r;
  assign clear    = accept & in_final_byte;

  always_comb begin
    push     = 1'b0;
    pop      = 1'b0;
    err_new  = 1'b0;
    status   = bbc_pkg::ST_OK;
    left     = 8'd0;
    line_nxt = line_r;
    col_nxt  = (col_r != bbc_pkg::POS_MAX) ? col_r + 16'd1 : col_r;

    if (match.is_open) begin
      if (stk.depth == DW'(bbc_pkg::STACK_DEPTH)) begin
        err_new = 1'b1;
        status  = bbc_pkg::ST_OVERFLOW;
      end else begin
        push = work;
      end
    end else if (match.is_close) begin
      if (stk.depth == '0 || stk.top != match.want) begin
        err_new = 1'b1;
        status  = bbc_pkg::ST_UNEXPECTED;
      end else begin
        pop = work;
      end
    end else if (in_source_byte == bbc_pkg::NEWLINE_BYTE) begin
      line_nxt = (line_r != bbc_pkg::POS_MAX) ? line_r + 16'd1 : line_r;
      col_nxt  = 16'd0;
    end

    // top of stack after this byte's push or pop
    if (match.is_open && !err_new) begin
      depth_after_nz = 1'b1;
      top_after      = in_source_byte;
    end else if (match.is_close && !err_new) begin
      depth_after_nz = (stk.depth != DW'(1));
      top_after      = stk.below;
    end else begin
      depth_after_nz = (stk.depth != '0);
      top_after      = stk.top;
    end

    if (in_final_byte && !err_new) begin
      if (depth_after_nz) begin
        status = bbc_pkg::ST_UNCLOSED;
        left   = top_after;
      end else begin
        status = bbc_pkg::ST_BALANCED;
      end
    end

    err_nxt = err_new;
    if (err_r) begin
      status   = bbc_pkg::ST_SKIPPED;
      left     = 8'd0;
      line_nxt = line_r;
      col_nxt  = col_r;
      err_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= 16'd1;
      col_r       <= 16'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (in_final_byte) begin
          line_r <= 16'd1;
          col_r  <= 16'd0;
          err_r  <= 1'b0;
        end else begin
          line_r <= line_nxt;
          col_r  <= col_nxt;
          err_r  <= err_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      status_r   <= status;
      line_out_r <= line_nxt;
      col_out_r  <= col_nxt;
      left_r     <= left;
      done_r     <= in_final_byte;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_line_number    = line_out_r;
  assign out_column_number  = col_out_r;
  assign out_open_byte_left = left_r;
  assign out_program_done   = done_r;

endmodule

[rtl/bbc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bbc_cfg.sv]
// APB-style configuration registers: pair count, opening and closing bytes.
// Depends on bbc_pkg.
module bbc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output bbc_pkg::cfg_t               cfg
);

  logic [2:0]  pair_count_r;
  logic [31:0] open_bytes_r;
  logic [31:0] close_bytes_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_count_r  <= 3'd0;
      open_bytes_r  <= 32'd0;
      close_bytes_r <= 32'd0;
    end else if (wr_en) begin
      case (reg_idx)
        bbc_pkg::REG_PAIR_COUNT:  pair_count_r  <= pwdata[2:0];
        bbc_pkg::REG_OPEN_BYTES:  open_bytes_r  <= pwdata;
        bbc_pkg::REG_CLOSE_BYTES: close_bytes_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bbc_pkg::REG_PAIR_COUNT:  prdata = {29'd0, pair_count_r};
      bbc_pkg::REG_OPEN_BYTES:  prdata = open_bytes_r;
      bbc_pkg::REG_CLOSE_BYTES: prdata = close_bytes_r;
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg.pair_count  = pair_count_r;
  assign cfg.open_bytes  = open_bytes_r;
  assign cfg.close_bytes = close_bytes_r;

endmodule

[rtl/bbc_match.sv]
// Parallel pair compare: classifies a byte as opener, closer or neither.
// Depends on bbc_pkg.
module bbc_match (
  input  bbc_pkg::cfg_t   cfg,
  input  logic [7:0]      byte_in,
  output bbc_pkg::match_t match
);

  logic       open_hit;
  logic       close_hit;
  logic [7:0] want;

  // scan from the highest pair down so the lowest-numbered hit wins
  always_comb begin
    open_hit  = 1'b0;
    close_hit = 1'b0;
    want      = 8'd0;
    for (int i = bbc_pkg::MAX_PAIRS - 1; i >= 0; i--) begin
      if (32'(i) < {29'd0, cfg.pair_count}) begin
        if (bbc_pkg::pair_byte(cfg.open_bytes, i) == byte_in) begin
          open_hit = 1'b1;
        end
        if (bbc_pkg::pair_byte(cfg.close_bytes, i) == byte_in) begin
          close_hit = 1'b1;
          want      = bbc_pkg::pair_byte(cfg.open_bytes, i);
        end
      end
    end
  end

  assign match.is_open  = open_hit;
  assign match.is_close = close_hit & ~open_hit;
  assign match.want     = want;

endmodule

[rtl/bbc_stack.sv]
// Opener stack: top entry in a register, the rest in a RAM whose read port
// always prefetches the entry below the top. Depends on bbc_pkg, bbc_ram.
module bbc_stack (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 pop,
  input  logic                 clear,
  input  logic [7:0]           push_byte,
  output bbc_pkg::stack_view_t view
);

  localparam int DW = bbc_pkg::DEPTH_W;
  localparam int AW = bbc_pkg::ADDR_W;

  logic [DW-1:0] depth_r, depth_nxt;
  logic [7:0]    top_r, top_nxt;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;
  logic          ram_we;
  logic [DW-1:0] waddr_full;
  logic [DW-1:0] raddr_full;
  logic [7:0]    ram_q;
  logic [7:0]    below;

  // old top goes to RAM on push; nothing to spill from an empty stack
  assign ram_we     = push & (depth_r != '0);
  assign waddr_full = depth_r - DW'(1);
  assign raddr_full = depth_nxt - DW'(2);

  // on push the prefetch address equals the write address: forward the data
  assign below = fwd_r ? fwd_data_r : ram_q;

  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    if (push) begin
      depth_nxt = depth_r + DW'(1);
      top_nxt   = push_byte;
    end else if (pop) begin
      depth_nxt = depth_r - DW'(1);
      top_nxt   = below;
    end
    if (clear) begin
      depth_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      fwd_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      if (push || pop || clear) begin
        fwd_r <= push;
      end
    end
    top_r <= top_nxt;
    if (push) begin
      fwd_data_r <= top_r;
    end
  end

  bbc_ram #(
    .WIDTH(8),
    .DEPTH(bbc_pkg::STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr_full[AW-1:0]),
    .wdata(top_r),
    .raddr(raddr_full[AW-1:0]),
    .rdata(ram_q)
  );

  assign view.depth = depth_r;
  assign view.top   = top_r;
  assign view.below = below;

endmodule

[rtl/bbc_checker.sv]
// Port-level checks for the bracket balance checker, bound to the top level.
// Depends on bbc_pkg.
module bbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [15:0] out_line_number,
  input logic [7:0]  out_open_byte_left,
  input logic        out_program_done
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
                               && $stable(out_line_number))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_left_only_unclosed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bbc_pkg::ST_UNCLOSED |-> out_open_byte_left == 8'd0)
    else $error("open byte reported without unclosed status");

  a_end_status_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bbc_pkg::ST_BALANCED
                  || out_status == bbc_pkg::ST_UNCLOSED) |-> out_program_done)
    else $error("end-of-program status on a non-final byte");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_number != 16'd0)
    else $error("line number zero");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_line_number   (out_line_number),
  .out_open_byte_left(out_open_byte_left),
  .out_program_done  (out_program_done)
);

[bench/tb_bracket_balance_checker.sv]
// Self-checking bench for bracket_balance_checker: random and directed programs
// are fed byte by byte and every result is compared with a built-in predictor.
// Depends on bbc_pkg and the bracket_balance_checker RTL.
`timescale 1ns / 100ps

module tb_bracket_balance_checker;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [31:0] MAIN_OPEN  = {8'h3C, 8'h7B, 8'h5B, 8'h28};  // < { [ (
  localparam logic [31:0] MAIN_CLOSE = {8'h3E, 8'h7D, 8'h5D, 8'h29};  // > } ] )

  typedef struct packed {
    bbc_pkg::status_t status;
    logic [15:0]      line_no;
    logic [15:0]      col_no;
    logic [7:0]       left;
    logic             done;
  } verdict_t;

  // Tracks the bracket stack, position and error latch of the program in flight.
  class balance_scoreboard;
    logic [7:0]  opener_stack [bbc_pkg::STACK_DEPTH];
    int unsigned depth;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    bit          halted;
    logic [2:0]  pair_cnt;
    logic [31:0] open_reg;
    logic [31:0] close_reg;
    verdict_t    expected_verdicts [$];
    int          mismatches;

    function new();
      pair_cnt   = '0;
      open_reg   = '0;
      close_reg  = '0;
      mismatches = 0;
      clear_program();
    endfunction

    function void clear_program();
      depth    = 0;
      cur_line = 16'd1;
      cur_col  = 16'd0;
      halted   = 1'b0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] val);
      case (idx)
        bbc_pkg::REG_PAIR_COUNT:  pair_cnt  = val[2:0];
        bbc_pkg::REG_OPEN_BYTES:  open_reg  = val;
        bbc_pkg::REG_CLOSE_BYTES: close_reg = val;
        default: ;
      endcase
    endfunction

    function int active_pairs();
      return (pair_cnt > bbc_pkg::MAX_PAIRS) ? bbc_pkg::MAX_PAIRS : int'(pair_cnt);
    endfunction

    // lowest-numbered pair whose byte in regv equals b, or -1
    function int lookup_pair(logic [31:0] regv, logic [7:0] b);
      for (int i = 0; i < active_pairs(); i++)
        if (regv[8*i +: 8] == b) return i;
      return -1;
    endfunction

    function void accept_byte(logic [7:0] b, logic fin);
      verdict_t v;
      int       p;
      v.status = bbc_pkg::ST_OK;
      v.left   = 8'h00;
      v.done   = fin;
      if (halted) begin
        v.status = bbc_pkg::ST_SKIPPED;
      end else begin
        if (cur_col != bbc_pkg::POS_MAX) cur_col++;
        p = lookup_pair(open_reg, b);
        if (p >= 0) begin
          if (depth >= bbc_pkg::STACK_DEPTH) begin
            v.status = bbc_pkg::ST_OVERFLOW;
            halted   = 1'b1;
          end else begin
            opener_stack[depth] = b;
            depth++;
          end
        end else begin
          p = lookup_pair(close_reg, b);
          if (p >= 0) begin
            if (depth == 0 || opener_stack[depth-1] != open_reg[8*p +: 8]) begin
              v.status = bbc_pkg::ST_UNEXPECTED;
              halted   = 1'b1;
            end else begin
              depth--;
            end
          end else if (b == bbc_pkg::NEWLINE_BYTE) begin
            if (cur_line != bbc_pkg::POS_MAX) cur_line++;
            cur_col = 16'd0;
          end
        end
        if (fin && !halted) begin
          if (depth > 0) begin
            v.status = bbc_pkg::ST_UNCLOSED;
            v.left   = opener_stack[depth-1];
          end else begin
            v.status = bbc_pkg::ST_BALANCED;
          end
        end
      end
      v.line_no = cur_line;
      v.col_no  = cur_col;
      expected_verdicts = {expected_verdicts, v};
      if (fin) clear_program();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_verdict(logic [2:0] st, logic [15:0] ln, logic [15:0] col,
                       logic [7:0] left, logic done);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, status %0d", st));
        return;
      end
      v = expected_verdicts.pop_front();
      if (st !== v.status)
        report_mismatch($sformatf("status %0d, want %0d", st, v.status));
      if (ln !== v.line_no)
        report_mismatch($sformatf("line %0d, want %0d", ln, v.line_no));
      if (col !== v.col_no)
        report_mismatch($sformatf("column %0d, want %0d", col, v.col_no));
      if (left !== v.left)
        report_mismatch($sformatf("open byte left %h, want %h", left, v.left));
      if (done !== v.done)
        report_mismatch($sformatf("program done %b, want %b", done, v.done));
    endtask
  endclass

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic [7:0]                  in_source_byte = 8'h00;
  logic                        in_final_byte  = 1'b0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic [2:0]                  out_status;
  logic [15:0]                 out_line_number;
  logic [15:0]                 out_column_number;
  logic [7:0]                  out_open_byte_left;
  logic                        out_program_done;
  logic                        psel           = 1'b0;
  logic                        penable        = 1'b0;
  logic                        pwrite         = 1'b0;
  logic [bbc_pkg::PADDR_W-1:0] paddr          = '0;
  logic [31:0]                 pwdata         = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  balance_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  bracket_balance_checker u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_byte     (in_source_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_line_number    (out_line_number),
    .out_column_number  (out_column_number),
    .out_open_byte_left (out_open_byte_left),
    .out_program_done   (out_program_done),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #1 clk = ~clk;

  // receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_verdict(out_status, out_line_number, out_column_number,
                       out_open_byte_left, out_program_done);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // all driving tasks start and end just after a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_config(input logic [2:0] pc, input logic [31:0] opens,
                              input logic [31:0] closes);
    write_reg(bbc_pkg::REG_PAIR_COUNT, {29'd0, pc});
    write_reg(bbc_pkg::REG_OPEN_BYTES, opens);
    write_reg(bbc_pkg::REG_CLOSE_BYTES, closes);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_source_byte <= b;
    in_final_byte  <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
    sb.accept_byte(b, fin);
    @(negedge clk);
  endtask

  // mostly well nested text with random content; sometimes left open or noisy
  task automatic send_program(input int max_len);
    int         pairs;
    int         len;
    int         r;
    int         p;
    int         nest [$];
    logic [7:0] b;
    pairs = sb.active_pairs();
    len   = $urandom_range(0, max_len);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30 && pairs > 0) begin
        p = $urandom_range(0, pairs - 1);
        nest = {nest, p};
        b = sb.open_reg[8*p +: 8];
      end else if (r < 55 && nest.size() > 0) begin
        p = nest[$];
        nest.delete(nest.size() - 1);
        b = sb.close_reg[8*p +: 8];
      end else if (r < 65) begin
        b = bbc_pkg::NEWLINE_BYTE;
      end else if (r < 72) begin
        b = 8'($urandom);
      end else begin
        b = 8'h61 + 8'($urandom_range(0, 25));
      end
      send_byte(b, 1'b0);
    end
    if ($urandom_range(0, 4) != 0) begin
      while (nest.size() > 0) begin
        p = nest[$];
        nest.delete(nest.size() - 1);
        send_byte(sb.close_reg[8*p +: 8], 1'b0);
      end
    end
    r = $urandom_range(0, 9);
    if (r < 6) b = 8'h61 + 8'($urandom_range(0, 25));
    else if (r < 8 || pairs == 0) b = 8'($urandom);
    else if (r == 8) b = sb.open_reg[8*$urandom_range(0, pairs - 1) +: 8];
    else if (nest.size() > 0) b = sb.close_reg[8*nest[$] +: 8];
    else b = bbc_pkg::NEWLINE_BYTE;
    send_byte(b, 1'b1);
  endtask

  // n openers then their closers, final flag on the last closer
  task automatic send_deep(input int n);
    int pairs;
    int p;
    int nest [$];
    pairs = sb.active_pairs();
    if (pairs == 0) return;
    repeat (n) begin
      p = $urandom_range(0, pairs - 1);
      nest = {nest, p};
      send_byte(sb.open_reg[8*p +: 8], 1'b0);
    end
    while (nest.size() > 1) begin
      p = nest[$];
      nest.delete(nest.size() - 1);
      send_byte(sb.close_reg[8*p +: 8], 1'b0);
    end
    p = nest[$];
    nest.delete(nest.size() - 1);
    send_byte(sb.close_reg[8*p +: 8], 1'b1);
  endtask

  task automatic run_phase(input int target);
    int base;
    base = items_sent;
    while (items_sent - base < target) begin
      if ($urandom_range(0, 39) == 0) send_deep($urandom_range(62, 68));
      else if ($urandom_range(0, 9) == 0) send_program(40);
      else send_program(12);
    end
  endtask

  // drop the request line and wait for every expected result
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_verdicts.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    logic [31:0] rnd_open;
    logic [31:0] rnd_close;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 68;
    write_config(3'd4, MAIN_OPEN, MAIN_CLOSE);

    // nested pairs across a newline, balanced at the end
    send_byte(8'h28, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(bbc_pkg::NEWLINE_BYTE, 1'b0);
    send_byte(8'h5D, 1'b0);
    send_byte(8'h29, 1'b1);
    // closer on an empty stack, as the last byte
    send_byte(8'h29, 1'b1);
    // wrong top, then bytes skipped up to the end
    send_byte(8'h28, 1'b0);
    send_byte(8'h5D, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'hFF, 1'b1);
    // left open at the end
    send_byte(8'h7B, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(bbc_pkg::NEWLINE_BYTE, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h3E, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte(8'h7D, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 68 : 0;
      recv_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 28 : 0;
      rnd_open  = $urandom;
      rnd_close = $urandom;
      rnd_close[15:8] = bbc_pkg::NEWLINE_BYTE;
      case (ph)
        0: write_config(3'd4, MAIN_OPEN, MAIN_CLOSE);
        1: write_config(3'd7, rnd_open, rnd_close);
        2: write_config(3'd0, 32'hFFFF_FFFF, 32'h0000_0000);
        3: write_config(3'd2, 32'h0000_0000, 32'hFFFF_FFFF);
        // newline as opener, closer shared by two pairs
        4: write_config(3'd5, {8'h7B, 8'h28, 8'h0A, 8'h5B}, {8'h7D, 8'h29, 8'h21, 8'h29});
        default: write_config(3'd4, MAIN_OPEN, MAIN_CLOSE);
      endcase
      if (ph == 0) begin
        send_deep(64);
        send_deep(65);
      end
      if (ph == 5) begin
        // hold the output so the block backs up onto its input
        hold_cycles = 60;
      end
      run_phase(28);
    end

    settle();
    repeat (4) @(posedge clk);
    if (sb.expected_verdicts.size() != 0)
      sb.report_mismatch("results still outstanding at the end");
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
